[hdl/fpts_pkg.sv]
package fpts_pkg;

  localparam int SlotsDef = 16;

  localparam logic [15:0] QuantumLowRst    = 16'd30;
  localparam logic [15:0] QuantumMediumRst = 16'd20;
  localparam logic [15:0] QuantumHighRst   = 16'd10;

  localparam logic [1:0] RS_OK    = 2'd0;
  localparam logic [1:0] RS_NONE  = 2'd1;
  localparam logic [1:0] RS_FULL  = 2'd2;
  localparam logic [1:0] RS_NORUN = 2'd3;

  localparam logic [1:0] LVL_LOW  = 2'd0;
  localparam logic [1:0] LVL_MED  = 2'd1;
  localparam logic [1:0] LVL_HIGH = 2'd2;

  typedef enum logic [3:0] {
    OP_CREATE      = 4'd0,
    OP_DISPATCH    = 4'd1,
    OP_TICK        = 4'd2,
    OP_WAIT_EVENT  = 4'd3,
    OP_SET_EVENT   = 4'd4,
    OP_WAIT_TICKS  = 4'd5,
    OP_CANCEL      = 4'd6,
    OP_TEST_CANCEL = 4'd7,
    OP_FINISH      = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    TS_FREE  = 2'd0,
    TS_READY = 2'd1,
    TS_WAIT  = 2'd2,
    TS_RUN   = 2'd3
  } thr_st_e;

  typedef struct packed {
    logic [3:0]  operation;
    logic [3:0]  thread_id;
    logic [1:0]  priority_req;
    logic        defer_sel;
    logic [7:0]  ev_num;
    logic [15:0] wait_ticks;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] affected_id;
    logic       running_valid;
    logic [3:0] running_id;
    logic [1:0] running_level;
    logic       level_changed;
    logic [4:0] woken_count;
  } out_word_t;

  typedef struct packed {
    thr_st_e     st;
    logic [1:0]  level;
    logic        defer;
    logic        pending;
    logic        timed;
    logic [7:0]  ev;
    logic [15:0] sleep_target;
    logic [15:0] sleep_elapsed;
    logic [31:0] stamp;
  } slot_rec_t;

  typedef struct packed {
    logic [15:0] low;
    logic [15:0] mid;
    logic [15:0] high;
  } quanta_t;

  function automatic logic [15:0] quantum_for(quanta_t q, logic [1:0] lv);
    logic [15:0] r;
    if (lv == LVL_LOW) begin
      r = q.low;
    end else if (lv == LVL_MED) begin
      r = q.mid;
    end else begin
      r = q.high;
    end
    return r;
  endfunction

endpackage

[hdl/fpts_in_if.sv]
interface fpts_in_if;
  logic               valid;
  logic               ready;
  fpts_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/fpts_out_if.sv]
interface fpts_out_if;
  logic                valid;
  logic                ready;
  fpts_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/fpts_cfg.sv]
module fpts_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output fpts_pkg::quanta_t quanta_o
);

  localparam logic [1:0] RegQLow  = 2'd0;
  localparam logic [1:0] RegQMed  = 2'd1;
  localparam logic [1:0] RegQHigh = 2'd2;

  fpts_pkg::quanta_t q_q, q_d;
  logic              wr;
  logic [1:0]        idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_comb begin
    q_d = q_q;
    if (wr) begin
      unique case (idx)
        RegQLow:  q_d.low  = pwdata[15:0];
        RegQMed:  q_d.mid  = pwdata[15:0];
        RegQHigh: q_d.high = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegQLow:  prdata = {16'b0, q_q.low};
      RegQMed:  prdata = {16'b0, q_q.mid};
      RegQHigh: prdata = {16'b0, q_q.high};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q.low  <= fpts_pkg::QuantumLowRst;
      q_q.mid  <= fpts_pkg::QuantumMediumRst;
      q_q.high <= fpts_pkg::QuantumHighRst;
    end else begin
      q_q <= q_d;
    end
  end

  assign quanta_o = q_q;

endmodule

[hdl/fpts_mem.sv]
module fpts_mem #(
  parameter int SLOTS = fpts_pkg::SlotsDef
) (
  input  logic                       clk_i,
  input  logic                       re_i,
  input  logic [$clog2(SLOTS)-1:0]   raddr_i,
  output fpts_pkg::slot_rec_t        rdata_o,
  input  logic                       we_i,
  input  logic [$clog2(SLOTS)-1:0]   waddr_i,
  input  fpts_pkg::slot_rec_t        wdata_i
);

  fpts_pkg::slot_rec_t mem_q [SLOTS];
  fpts_pkg::slot_rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/feedback_priority_thread_scheduler.sv]
// Channel   Dir  Port    Word
// request   in   in_i    operation, thread_id, priority_req, defer_sel, ev_num, wait_ticks
// result    out  res_o   status, affected_id, running_*, level_changed, woken_count
// config    in   APB     quantum_low @0, quantum_medium @4, quantum_high @8
//
// Create, finish and rejected words go from idle straight to the result state.
// Wait, cancel, test cancel: one read-modify-write of the slot memory.
// Dispatch, set event: a scan of all slots, one slot read per cycle from the slot memory.
// Tick: an aging scan, a pick scan per woken thread and a last one; RMW on a preemption.
// Reset frees all slots at once through per-slot valid flops; no clearing pass.
// A held result does not block acceptance; the next result waits for it.
module feedback_priority_thread_scheduler #(
  parameter int SLOTS = fpts_pkg::SlotsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fpts_in_if.sink      in_i,
  fpts_out_if.source   res_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int IdxW = $clog2(SLOTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_COMMIT = 6'b000100,
    S_RMW_RD = 6'b001000,
    S_RMW_WR = 6'b010000,
    S_RESP   = 6'b100000
  } state_e;

  fpts_pkg::quanta_t   quanta;
  fpts_pkg::slot_rec_t rd_rec, wdata;
  logic                mem_re, mem_we;
  logic [IdxW-1:0]     mem_raddr, mem_waddr;

  fpts_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .quanta_o (quanta)
  );

  fpts_mem #(.SLOTS(SLOTS)) u_mem (
    .clk_i,
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_rec),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wdata)
  );

  state_e              state_q, state_d;
  fpts_pkg::op_e       op_q, op_d;
  logic [7:0]          ev_q, ev_d;
  logic [15:0]         wt_q, wt_d;
  logic [31:0]         cnt_q, cnt_d;
  logic [SLOTS-1:0]    valid_q, valid_d, cand_q, cand_d;
  logic [IdxW-1:0]     run_slot_q, run_slot_d;
  logic                present_q, present_d;
  logic [1:0]          run_level_q, run_level_d;
  logic [15:0]         qe_q, qe_d;
  logic [IdxW-1:0]     scan_idx_q, scan_idx_d, rd_idx_q, rd_idx_d;
  logic                iss_done_q, iss_done_d, rd_vld_q, rd_vld_d, pick_q, pick_d;
  logic                best_vld_q, best_vld_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;
  logic [31:0]         best_age_q, best_age_d;
  fpts_pkg::slot_rec_t best_rec_q, best_rec_d;
  logic [IdxW-1:0]     rmw_addr_q, rmw_addr_d;
  logic [1:0]          status_q, status_d;
  logic [3:0]          affected_q, affected_d;
  logic                changed_q, changed_d;
  logic [4:0]          woken_q, woken_d;
  logic                out_vld_q, out_vld_d;
  fpts_pkg::out_word_t out_q, out_d;

  fpts_pkg::op_e   in_op;
  logic [1:0]      prio_clip;
  logic            free_found, tid_ok, cand;
  logic [IdxW-1:0] free_idx, tid_idx;
  logic [31:0]     age;
  logic [15:0]     el_inc;
  logic [1:0]      lv_new;
  logic            lv_chg;

  assign in_op     = fpts_pkg::op_e'(in_i.data.operation);
  assign prio_clip = (in_i.data.priority_req == 2'd3) ? fpts_pkg::LVL_HIGH
                                                      : in_i.data.priority_req;
  assign tid_ok    = 32'(in_i.data.thread_id) < 32'(SLOTS);
  assign tid_idx   = IdxW'(in_i.data.thread_id);
  assign age       = cnt_q - rd_rec.stamp;
  assign el_inc    = (rd_rec.sleep_elapsed == 16'hFFFF) ? rd_rec.sleep_elapsed
                                                        : rd_rec.sleep_elapsed + 16'd1;
  assign in_i.ready = (state_q == S_IDLE);
  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(k);
      end
    end
  end

  // level move of a thread leaving to wait
  always_comb begin
    lv_new = rd_rec.level;
    lv_chg = 1'b0;
    if (qe_q < fpts_pkg::quantum_for(quanta, rd_rec.level)) begin
      if (rd_rec.level < fpts_pkg::LVL_HIGH) begin
        lv_new = rd_rec.level + 2'd1;
        lv_chg = 1'b1;
      end
    end else if (rd_rec.level != fpts_pkg::LVL_LOW) begin
      lv_new = rd_rec.level - 2'd1;
      lv_chg = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ev_d        = ev_q;
    wt_d        = wt_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    cand_d      = cand_q;
    run_slot_d  = run_slot_q;
    present_d   = present_q;
    run_level_d = run_level_q;
    qe_d        = qe_q;
    scan_idx_d  = scan_idx_q;
    iss_done_d  = iss_done_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = scan_idx_q;
    pick_d      = pick_q;
    best_vld_d  = best_vld_q;
    best_idx_d  = best_idx_q;
    best_age_d  = best_age_q;
    best_rec_d  = best_rec_q;
    rmw_addr_d  = rmw_addr_q;
    status_d    = status_q;
    affected_d  = affected_q;
    changed_d   = changed_q;
    woken_d     = woken_q;
    out_vld_d   = out_vld_q;
    out_d       = out_q;
    mem_re      = 1'b0;
    mem_raddr   = scan_idx_q;
    mem_we      = 1'b0;
    mem_waddr   = rmw_addr_q;
    wdata       = rd_rec;
    cand        = 1'b0;

    if (out_vld_q && res_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d       = in_op;
          ev_d       = in_i.data.ev_num;
          wt_d       = in_i.data.wait_ticks;
          status_d   = fpts_pkg::RS_OK;
          affected_d = '0;
          changed_d  = 1'b0;
          woken_d    = '0;
          state_d    = S_RESP;
          scan_idx_d = '0;
          iss_done_d = 1'b0;
          best_vld_d = 1'b0;
          unique case (in_op) inside
            fpts_pkg::OP_CREATE: begin
              if (!free_found) begin
                status_d = fpts_pkg::RS_FULL;
              end else begin
                mem_we              = 1'b1;
                mem_waddr           = free_idx;
                wdata.st            = fpts_pkg::TS_READY;
                wdata.level         = prio_clip;
                wdata.defer         = in_i.data.defer_sel;
                wdata.pending       = 1'b0;
                wdata.timed         = 1'b0;
                wdata.ev            = '0;
                wdata.sleep_target  = '0;
                wdata.sleep_elapsed = '0;
                wdata.stamp         = cnt_q;
                cnt_d               = cnt_q + 32'd1;
                valid_d[free_idx]   = 1'b1;
                affected_d          = 4'(free_idx);
              end
            end
            fpts_pkg::OP_DISPATCH: begin
              if (!present_q) begin
                state_d = S_SCAN;
              end
            end
            fpts_pkg::OP_TICK: begin
              if (present_q && qe_q != 16'hFFFF) begin
                qe_d = qe_q + 16'd1;
              end
              pick_d  = 1'b0;
              cand_d  = '0;
              state_d = S_SCAN;
            end
            fpts_pkg::OP_SET_EVENT: begin
              state_d = S_SCAN;
            end
            fpts_pkg::OP_WAIT_EVENT, fpts_pkg::OP_WAIT_TICKS,
            fpts_pkg::OP_TEST_CANCEL: begin
              if (!present_q) begin
                status_d = fpts_pkg::RS_NORUN;
              end else begin
                rmw_addr_d = run_slot_q;
                state_d    = S_RMW_RD;
              end
            end
            fpts_pkg::OP_CANCEL: begin
              if (!tid_ok || !valid_q[tid_idx]) begin
                status_d = fpts_pkg::RS_NONE;
              end else begin
                rmw_addr_d = tid_idx;
                state_d    = S_RMW_RD;
              end
            end
            fpts_pkg::OP_FINISH: begin
              if (!present_q) begin
                status_d = fpts_pkg::RS_NORUN;
              end else begin
                valid_d[run_slot_q] = 1'b0;
                present_d           = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        mem_re   = !iss_done_q;
        rd_vld_d = !iss_done_q;
        if (!iss_done_q) begin
          if (scan_idx_q == LastIdx) begin
            iss_done_d = 1'b1;
          end else begin
            scan_idx_d = scan_idx_q + 1'b1;
          end
        end
        if (rd_vld_q) begin
          case (op_q)
            fpts_pkg::OP_DISPATCH: begin
              cand = valid_q[rd_idx_q] && rd_rec.st == fpts_pkg::TS_READY;
            end
            fpts_pkg::OP_SET_EVENT: begin
              cand = valid_q[rd_idx_q] && rd_rec.st == fpts_pkg::TS_WAIT &&
                     !rd_rec.timed && rd_rec.ev == ev_q;
            end
            fpts_pkg::OP_TICK: begin
              if (pick_q) begin
                cand = cand_q[rd_idx_q];
              end else if (valid_q[rd_idx_q] && rd_rec.st == fpts_pkg::TS_WAIT &&
                           rd_rec.timed) begin
                mem_we              = 1'b1;
                mem_waddr           = rd_idx_q;
                wdata.sleep_elapsed = el_inc;
                cand_d[rd_idx_q]    = el_inc >= rd_rec.sleep_target;
              end
            end
            default: ;
          endcase
          if (cand && (!best_vld_q || rd_rec.level > best_rec_q.level ||
              (rd_rec.level == best_rec_q.level && age > best_age_q))) begin
            best_vld_d = 1'b1;
            best_idx_d = rd_idx_q;
            best_rec_d = rd_rec;
            best_age_d = age;
          end
          if (rd_idx_q == LastIdx) begin
            state_d = S_COMMIT;
          end
        end
      end

      S_COMMIT: begin
        state_d   = S_RESP;
        mem_waddr = best_idx_q;
        wdata     = best_rec_q;
        case (op_q)
          fpts_pkg::OP_DISPATCH: begin
            if (!best_vld_q) begin
              status_d = fpts_pkg::RS_NONE;
            end else begin
              mem_we      = 1'b1;
              wdata.st    = fpts_pkg::TS_RUN;
              run_slot_d  = best_idx_q;
              present_d   = 1'b1;
              run_level_d = best_rec_q.level;
              qe_d        = '0;
            end
          end
          fpts_pkg::OP_SET_EVENT: begin
            if (!best_vld_q) begin
              status_d = fpts_pkg::RS_NONE;
            end else begin
              mem_we      = 1'b1;
              wdata.st    = fpts_pkg::TS_READY;
              wdata.stamp = cnt_q;
              cnt_d       = cnt_q + 32'd1;
              affected_d  = 4'(best_idx_q);
            end
          end
          fpts_pkg::OP_TICK: begin
            scan_idx_d = '0;
            iss_done_d = 1'b0;
            best_vld_d = 1'b0;
            if (!pick_q) begin
              pick_d  = 1'b1;
              state_d = S_SCAN;
            end else if (best_vld_q) begin
              mem_we              = 1'b1;
              wdata.st            = fpts_pkg::TS_READY;
              wdata.timed         = 1'b0;
              wdata.sleep_elapsed = '0;
              wdata.stamp         = cnt_q;
              cnt_d               = cnt_q + 32'd1;
              cand_d[best_idx_q]  = 1'b0;
              if (woken_q != 5'h1F) begin
                woken_d = woken_q + 5'd1;
              end
              state_d = S_SCAN;
            end else if (present_q &&
                         qe_q >= fpts_pkg::quantum_for(quanta, run_level_q)) begin
              rmw_addr_d = run_slot_q;
              state_d    = S_RMW_RD;
            end
          end
          default: ;
        endcase
      end

      S_RMW_RD: begin
        mem_re    = 1'b1;
        mem_raddr = rmw_addr_q;
        state_d   = S_RMW_WR;
      end

      S_RMW_WR: begin
        state_d = S_RESP;
        case (op_q)
          fpts_pkg::OP_TICK: begin
            if (rd_rec.level != fpts_pkg::LVL_LOW) begin
              wdata.level = rd_rec.level - 2'd1;
              changed_d   = 1'b1;
            end
            wdata.st    = fpts_pkg::TS_READY;
            wdata.stamp = cnt_q;
            cnt_d       = cnt_q + 32'd1;
            mem_we      = 1'b1;
            present_d   = 1'b0;
          end
          fpts_pkg::OP_WAIT_EVENT, fpts_pkg::OP_WAIT_TICKS: begin
            if (op_q == fpts_pkg::OP_WAIT_EVENT) begin
              wdata.ev    = ev_q;
              wdata.timed = 1'b0;
            end else begin
              wdata.timed         = 1'b1;
              wdata.sleep_target  = wt_q;
              wdata.sleep_elapsed = '0;
            end
            wdata.level = lv_new;
            changed_d   = lv_chg;
            wdata.st    = fpts_pkg::TS_WAIT;
            wdata.stamp = cnt_q;
            cnt_d       = cnt_q + 32'd1;
            mem_we      = 1'b1;
            present_d   = 1'b0;
          end
          fpts_pkg::OP_CANCEL: begin
            if (rd_rec.st != fpts_pkg::TS_READY && rd_rec.st != fpts_pkg::TS_WAIT) begin
              status_d = fpts_pkg::RS_NONE;
            end else begin
              affected_d = 4'(rmw_addr_q);
              if (rd_rec.defer) begin
                wdata.pending = 1'b1;
                mem_we        = 1'b1;
              end else begin
                valid_d[rmw_addr_q] = 1'b0;
              end
            end
          end
          fpts_pkg::OP_TEST_CANCEL: begin
            if (!rd_rec.pending) begin
              status_d = fpts_pkg::RS_NONE;
            end else begin
              affected_d          = 4'(rmw_addr_q);
              valid_d[rmw_addr_q] = 1'b0;
              present_d           = 1'b0;
            end
          end
          default: ;
        endcase
      end

      S_RESP: begin
        if (!out_vld_q || res_o.ready) begin
          out_vld_d           = 1'b1;
          out_d.status        = status_q;
          out_d.affected_id   = affected_q;
          out_d.running_valid = present_q;
          out_d.running_id    = present_q ? 4'(run_slot_q) : 4'd0;
          out_d.running_level = present_q ? run_level_q : 2'd0;
          out_d.level_changed = changed_q;
          out_d.woken_count   = woken_q;
          state_d             = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      cand_q      <= '0;
      run_slot_q  <= '0;
      present_q   <= 1'b0;
      run_level_q <= '0;
      qe_q        <= '0;
      scan_idx_q  <= '0;
      iss_done_q  <= 1'b0;
      rd_vld_q    <= 1'b0;
      pick_q      <= 1'b0;
      best_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      cand_q      <= cand_d;
      run_slot_q  <= run_slot_d;
      present_q   <= present_d;
      run_level_q <= run_level_d;
      qe_q        <= qe_d;
      scan_idx_q  <= scan_idx_d;
      iss_done_q  <= iss_done_d;
      rd_vld_q    <= rd_vld_d;
      pick_q      <= pick_d;
      best_vld_q  <= best_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    ev_q       <= ev_d;
    wt_q       <= wt_d;
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_age_q <= best_age_d;
    best_rec_q <= best_rec_d;
    rmw_addr_q <= rmw_addr_d;
    status_q   <= status_d;
    affected_q <= affected_d;
    changed_q  <= changed_d;
    woken_q    <= woken_d;
    out_q      <= out_d;
  end

`ifndef SYNTHESIS
  a_run_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    present_q |-> valid_q[run_slot_q])
    else $error("running slot is free");

  a_rmw_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RMW_WR |-> $past(state_q) == S_RMW_RD)
    else $error("slot write-back without read");

  a_woken_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESP |-> int'(woken_q) <= SLOTS)
    else $error("more wakeups than slots");
`endif

endmodule
